// File: design/mrtu_pkg.sv
package mrtu_pkg;

  // frame length limits
  localparam int MAX_FRAME_DEF = 256;
  localparam int MIN_FRAME_DEF = 4;

  // crc-16/modbus constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // fc bit that marks an exception reply
  localparam int EXC_BIT = 7;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_SHORT    = 3'd1,
    ST_CRC_ERROR    = 3'd2,
    ST_FORMAT_ERROR = 3'd3,
    ST_EXCEPTION    = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] slave_addr;
    logic [7:0] function_code;
    logic [7:0] exc_code;
    logic [7:0] data_len;
  } result_t;

  // one byte through the reflected crc, bit by bit
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/mrtu_frame_state.sv
module mrtu_frame_state #(
  parameter int MAX_FRAME = mrtu_pkg::MAX_FRAME_DEF,
  parameter int MIN_FRAME = mrtu_pkg::MIN_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  mrtu_pkg::item_t   item,
  output mrtu_pkg::result_t res
);
  import mrtu_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int LEN_W = CNT_W + 1;

  logic [15:0]      crc_acc;
  logic [7:0]       dly0;
  logic [7:0]       dly1;
  logic [CNT_W-1:0] rx_count;
  logic             overlong;
  logic [7:0]       hdr0;
  logic [7:0]       hdr1;
  logic [7:0]       hdr2;

  logic [15:0]      crc_now;
  logic [LEN_W-1:0] len;
  logic [15:0]      recv;
  logic             at_max;

  // running crc lags two bytes behind the stream
  assign crc_now = (rx_count >= CNT_W'(2)) ? crc_feed(crc_acc, dly0) : crc_acc;
  assign len     = LEN_W'(rx_count) + LEN_W'(1);
  assign recv    = {item.data_byte, dly1};
  assign at_max  = (rx_count >= CNT_W'(MAX_FRAME));

  // frame state, cleared after the last beat of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc  <= CRC_INIT;
      dly0     <= '0;
      dly1     <= '0;
      rx_count <= '0;
      overlong <= 1'b0;
      hdr0     <= '0;
      hdr1     <= '0;
      hdr2     <= '0;
    end else if (step) begin
      if (item.last) begin
        crc_acc  <= CRC_INIT;
        dly0     <= '0;
        dly1     <= '0;
        rx_count <= '0;
        overlong <= 1'b0;
        hdr0     <= '0;
        hdr1     <= '0;
        hdr2     <= '0;
      end else begin
        crc_acc <= crc_now;
        dly0    <= dly1;
        dly1    <= item.data_byte;
        if (rx_count == CNT_W'(0)) hdr0 <= item.data_byte;
        if (rx_count == CNT_W'(1)) hdr1 <= item.data_byte;
        if (rx_count == CNT_W'(2)) hdr2 <= item.data_byte;
        if (at_max) begin
          overlong <= 1'b1;
        end else begin
          rx_count <= rx_count + CNT_W'(1);
        end
      end
    end
  end

  // classify the frame on its last byte
  always_comb begin
    res = '0;
    res.status = ST_OK;
    if (len < LEN_W'(MIN_FRAME)) begin
      res.status = ST_TOO_SHORT;
    end else if (overlong || len > LEN_W'(MAX_FRAME)) begin
      res.status = ST_FORMAT_ERROR;
    end else if (crc_now != recv) begin
      res.status = ST_CRC_ERROR;
    end else begin
      res.slave_addr    = hdr0;
      res.function_code = hdr1;
      if (hdr1[EXC_BIT]) begin
        if (len < LEN_W'(5)) begin
          res.status = ST_FORMAT_ERROR;
        end else begin
          res.status   = ST_EXCEPTION;
          res.exc_code = hdr2;
          res.data_len = 8'd1;
        end
      end else if (len <= LEN_W'(4)) begin
        res.status = ST_FORMAT_ERROR;
      end else begin
        res.status   = ST_OK;
        res.data_len = 8'(len - LEN_W'(4));
      end
    end
  end

endmodule

// File: design/modbus_rtu_frame_checker_unit.sv
// channel | direction | handshake                 | beat payload
// item    | in        | item_valid / item_ready   | item_t: data_byte, last
// res     | out       | res_valid  / res_ready    | result_t: status .. data_len
//
// one byte per cycle sustained while no result stalls; a byte is registered in the input register, then
// goes through the 8-step crc update and frame checks, and the result of a frame's last byte is
// registered in the result register.
// synchronous reset clears the frame state and both valid flags.
// a stalled result holds only the last byte of the next frame; other bytes keep flowing.
module modbus_rtu_frame_checker_unit #(
  parameter int MAX_FRAME = mrtu_pkg::MAX_FRAME_DEF,
  parameter int MIN_FRAME = mrtu_pkg::MIN_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  mrtu_pkg::item_t   item,
  output logic              res_valid,
  input  logic              res_ready,
  output mrtu_pkg::result_t res
);
  import mrtu_pkg::*;

  logic    inq_valid;
  item_t   inq;
  logic    advance;
  result_t res_next;

  // the stage moves on unless a result beat has nowhere to go
  assign advance    = inq_valid && (!inq.last || !res_valid || res_ready);
  assign item_ready = !inq_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (item_ready) begin
      inq_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      inq <= item;
    end
  end

  mrtu_frame_state #(
    .MAX_FRAME (MAX_FRAME),
    .MIN_FRAME (MIN_FRAME)
  ) u_state (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (inq),
    .res  (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && inq.last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && inq.last) begin
      res <= res_next;
    end
  end

  // checks
  a_exc_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_EXCEPTION |-> res.data_len == 8'd1)
    else $error("exception result without payload length one");

  a_crc_hdr: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_CRC_ERROR |->
      res.slave_addr == 8'd0 && res.function_code == 8'd0)
    else $error("crc error result carries header bytes");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> inq_valid && inq.last && res_valid && !res_ready)
    else $error("input stalled without a blocked result");

  a_load: assert property (@(posedge clk) disable iff (rst)
    advance && inq.last |=> res_valid)
    else $error("last byte left no result");

endmodule

// File: tb/sv/modbus_rtu_frame_checker_unit_tb.sv
module modbus_rtu_frame_checker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrtu_pkg::*;

  localparam int MAX_LEN      = MAX_FRAME_DEF;
  localparam int MIN_LEN      = MIN_FRAME_DEF;
  // address, function code and the two crc bytes
  localparam int FRAME_FIXED  = 4;
  // exception reply needs its code byte as well
  localparam int EXC_MIN_LEN  = 5;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 65;
  localparam result_t NO_VERDICT = '0;

  logic    clk        = 1'b0;
  logic    rst        = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item       = '0;
  logic    res_valid;
  logic    res_ready  = 1'b0;
  result_t res;

  modbus_rtu_frame_checker_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // frame state of the predictor
  logic [15:0] crc_run;
  logic [7:0]  two_back;
  logic [7:0]  one_back;
  int unsigned bytes_seen;
  bit          too_long;
  logic [7:0]  header_copy [3];

  result_t     verdict_q [$];
  int          err_count       = 0;
  int          bytes_sent      = 0;
  int          frames_sent     = 0;
  int          verdicts_seen   = 0;
  int          src_idle_pct    = 0;
  int          sink_idle_pct   = 0;
  int          hold_asked      = 0;
  int          hold_served     = 0;
  int          hold_left       = 0;
  int          quiet_cycles    = 0;

  // reflected crc, one data bit per shift
  function automatic logic [15:0] frame_crc_byte(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ d[i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void frame_clear();
    crc_run    = CRC_INIT;
    two_back   = '0;
    one_back   = '0;
    bytes_seen = 0;
    too_long   = 1'b0;
    foreach (header_copy[i]) header_copy[i] = '0;
  endfunction

  // advance the predictor by one byte; returns 1 when the frame closes
  function automatic bit frame_verdict_step(input logic [7:0] b, input bit l,
                                            output result_t r);
    logic [15:0] c;
    int unsigned n;
    r = NO_VERDICT;
    c = crc_run;
    if (bytes_seen >= 2) c = frame_crc_byte(c, two_back);
    if (bytes_seen < 3) header_copy[bytes_seen] = b;
    if (!l) begin
      crc_run  = c;
      two_back = one_back;
      one_back = b;
      if (bytes_seen >= MAX_LEN) too_long = 1'b1;
      else bytes_seen++;
      return 1'b0;
    end
    n = bytes_seen + 1;
    if (n < MIN_LEN) begin
      r.status = ST_TOO_SHORT;
    end else if (too_long || n > MAX_LEN) begin
      r.status = ST_FORMAT_ERROR;
    end else if (c != {b, one_back}) begin
      r.status = ST_CRC_ERROR;
    end else begin
      r.slave_addr    = header_copy[0];
      r.function_code = header_copy[1];
      if (header_copy[1][EXC_BIT]) begin
        if (n < EXC_MIN_LEN) begin
          r.status = ST_FORMAT_ERROR;
        end else begin
          r.status   = ST_EXCEPTION;
          r.exc_code = header_copy[2];
          r.data_len = 8'd1;
        end
      end else if (n <= FRAME_FIXED) begin
        r.status = ST_FORMAT_ERROR;
      end else begin
        r.status   = ST_OK;
        r.data_len = 8'(n - FRAME_FIXED);
      end
    end
    frame_clear();
    return 1'b1;
  endfunction

  // directed frames: header bytes, length, crc corruption, typed verdict
  typedef struct {
    logic [7:0] addr;
    logic [7:0] fc;
    logic [7:0] b2;
    int         len;
    bit         crc_bad;
    bit         typed;
    result_t    want;
  } frame_row_t;

  frame_row_t directed_rows [18] = '{
    '{8'h00, 8'h00, 8'h00,   1, 0, 1, '{ST_TOO_SHORT,    8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'hff, 8'hff, 8'hff,   2, 0, 1, '{ST_TOO_SHORT,    8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h01, 8'h03, 8'h00,   3, 0, 1, '{ST_TOO_SHORT,    8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h11, 8'h03, 8'h00,   4, 0, 1, '{ST_FORMAT_ERROR, 8'h11, 8'h03, 8'h00, 8'h00}},
    '{8'h11, 8'h83, 8'h00,   4, 0, 1, '{ST_FORMAT_ERROR, 8'h11, 8'h83, 8'h00, 8'h00}},
    '{8'h01, 8'h03, 8'haa,   5, 0, 1, '{ST_OK,           8'h01, 8'h03, 8'h00, 8'h01}},
    '{8'h01, 8'h83, 8'h02,   5, 0, 1, '{ST_EXCEPTION,    8'h01, 8'h83, 8'h02, 8'h01}},
    '{8'hff, 8'hff, 8'hff,   5, 0, 1, '{ST_EXCEPTION,    8'hff, 8'hff, 8'hff, 8'h01}},
    '{8'h00, 8'h00, 8'h00,   5, 0, 1, '{ST_OK,           8'h00, 8'h00, 8'h00, 8'h01}},
    '{8'h01, 8'h03, 8'h00,   8, 1, 1, '{ST_CRC_ERROR,    8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h01, 8'h83, 8'h04,   5, 1, 1, '{ST_CRC_ERROR,    8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h22, 8'h06, 8'h00,   4, 1, 1, '{ST_CRC_ERROR,    8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h05, 8'h10, 8'h00,   8, 0, 0, NO_VERDICT},
    '{8'h7f, 8'h7f, 8'h01,   6, 0, 0, NO_VERDICT},
    '{8'hf7, 8'h81, 8'h0b,   9, 0, 1, '{ST_EXCEPTION,    8'hf7, 8'h81, 8'h0b, 8'h01}},
    '{8'h0a, 8'h04, 8'h00, 256, 0, 1, '{ST_OK,           8'h0a, 8'h04, 8'h00, 8'hfc}},
    '{8'h0a, 8'h04, 8'h00, 257, 0, 1, '{ST_FORMAT_ERROR, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{8'h0b, 8'h03, 8'h00, 258, 0, 1, '{ST_FORMAT_ERROR, 8'h00, 8'h00, 8'h00, 8'h00}}
  };

  // offer one byte, wait for its beat, then record the verdict it closes
  task automatic send_beat(input logic [7:0] b, input bit l, input bit typed,
                           input result_t want);
    result_t v;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{data_byte: b, last: l};
    do @(posedge clk); while (!item_ready);
    bytes_sent++;
    if (frame_verdict_step(b, l, v)) begin
      verdict_q.push_back(typed ? want : v);
      frames_sent++;
    end
  endtask

  // header, random body, then the trailing crc (optionally corrupted)
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] fc, input logic [7:0] b2,
                            input int len, input bit crc_bad, input bit typed,
                            input result_t want);
    logic [7:0]  fb [];
    logic [15:0] crc;
    fb = new[len];
    foreach (fb[i]) begin
      fb[i] = (i == 0) ? addr : (i == 1) ? fc : (i == 2) ? b2 : 8'($urandom_range(0, 255));
    end
    if (len >= FRAME_FIXED) begin
      crc = CRC_INIT;
      for (int i = 0; i < len - 2; i++) crc = frame_crc_byte(crc, fb[i]);
      fb[len - 2] = crc[7:0];
      fb[len - 1] = crc[15:8];
      if (crc_bad) fb[len - 1 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    end
    foreach (fb[i]) send_beat(fb[i], i == len - 1, typed, want);
  endtask

  // mostly well-formed frames, some corrupted, short, raw noise and oversized
  task automatic random_traffic(input int budget);
    int         start;
    int         pick;
    int         len;
    logic [7:0] a;
    logic [7:0] f;
    logic [7:0] x;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      a    = 8'($urandom_range(0, 255));
      f    = 8'($urandom_range(0, 255));
      x    = 8'($urandom_range(0, 255));
      if (pick < 12) begin
        // raw bytes with last set at random
        repeat ($urandom_range(1, 12)) begin
          send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0, 1'b0, NO_VERDICT);
        end
      end else if (pick < 20) begin
        send_frame(a, f, x, $urandom_range(1, 3), 1'b0, 1'b0, NO_VERDICT);
      end else if (pick < 98) begin
        len = $urandom_range(FRAME_FIXED, ($urandom_range(0, 3) == 0) ? 40 : 10);
        send_frame(a, f, x, len, $urandom_range(0, 6) == 0, 1'b0, NO_VERDICT);
      end else if (pick < 99) begin
        send_frame(a, f, x, $urandom_range(MAX_LEN - 6, MAX_LEN), 1'b0, 1'b0, NO_VERDICT);
      end else begin
        send_frame(a, f, x, $urandom_range(MAX_LEN + 1, MAX_LEN + 40),
                   $urandom_range(0, 1) == 1, 1'b0, NO_VERDICT);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
      err_count++;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (verdict_q.size() == 0) begin
      $error("result beat with no frame pending: status %0d", got.status);
      err_count++;
      return;
    end
    want = verdict_q.pop_front();
    verdicts_seen++;
    check_field("status", 8'(want.status), 8'(got.status));
    check_field("slave_addr", want.slave_addr, got.slave_addr);
    check_field("function_code", want.function_code, got.function_code);
    check_field("exc_code", want.exc_code, got.exc_code);
    check_field("data_len", want.data_len, got.data_len);
  endtask

  // result side: compare each beat, then pick the next ready level
  always @(posedge clk) begin
    if (res_valid && res_ready) check_result(res);
    if (hold_left != 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      res_ready   <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (res_valid && res_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d verdicts pending",
               quiet_cycles, verdict_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    frame_clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver heavily
    src_idle_pct = 22;
    sink_idle_pct <= 54;
    foreach (directed_rows[r]) begin
      send_frame(directed_rows[r].addr, directed_rows[r].fc, directed_rows[r].b2,
                 directed_rows[r].len, directed_rows[r].crc_bad, directed_rows[r].typed,
                 directed_rows[r].want);
    end
    random_traffic(RANDOM_BYTES);

    // roles swapped
    src_idle_pct = 54;
    sink_idle_pct <= 22;
    random_traffic(RANDOM_BYTES);

    // full rate, with one long receiver hold-off to back up the input
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    hold_asked <= hold_asked + 1;
    random_traffic(RANDOM_BYTES);
    item_valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("frame checker: %0d bytes in %0d frames, %0d verdicts compared", bytes_sent,
             frames_sent, verdicts_seen);
    $display("short, overlong, exception and bad-crc frames under three idle mixes and a hold-off");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
